FILE: hdl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants for the 3x3 replicate-edge box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int LINE_MAX    = 1024;
  localparam int COL_W       = $clog2(LINE_MAX);
  localparam int PIX_W       = 8;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int HEIGHT_MAX  = 4096;
  localparam int ROW_W       = 12;
  localparam int ROW_SAT     = 4095;
  localparam int OCNT_W      = 22;
  localparam int TOTAL_W     = OCNT_W + 1;
  localparam int POS_ROW_W   = OCNT_W - 1;
  localparam int CNT_W       = $clog2(OCNT_W);
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int COLSUM_W    = PIX_W + 2;
  localparam int SUM_W       = PIX_W + 4;
  // floor(s / 9) = (s * 3641) >> 15, exact for s < 32768
  localparam int RECIP       = 3641;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 15;
  localparam int WIDTH_RST   = 512;
  localparam int HEIGHT_RST  = 512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_t;

  typedef struct packed {
    logic             item_kind;
    logic [PIX_W-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_beat_t;

  // per-item control decided at accept time
  typedef struct packed {
    logic emit;
    logic last;
    logic top_rep;
    logic bot_rep;
    logic left_rep;
    logic right_rep;
  } item_ctl_t;

  // one window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

endpackage

FILE: hdl/bbr_ctrl.sv
// ----------------------------------------------------------------------------
// bbr_ctrl
// Config registers, raster and output position counters, and a serial
// divider that rebuilds the output row/column after a config write.
// ----------------------------------------------------------------------------
module bbr_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  output logic                           busy,
  output logic [bbr_pkg::COL_W-1:0]      col_addr,
  output bbr_pkg::item_ctl_t             ctl
);
  import bbr_pkg::*;

  logic [WIDTH_W-1:0]   image_width;
  logic [HEIGHT_W-1:0]  image_height;
  logic [WIDTH_W-1:0]   eff_w;
  logic [HEIGHT_W-1:0]  eff_h;
  logic [TOTAL_W-1:0]   total;

  logic [COL_W-1:0]     column_count;
  logic [ROW_W-1:0]     row_count;
  logic [OCNT_W-1:0]    out_count;
  logic [POS_ROW_W-1:0] pos_row;
  logic [COL_W-1:0]     pos_col;

  div_state_t           state, state_next;
  logic [WIDTH_W-1:0]   div_rem, div_rem_next, rem_sh;
  logic [OCNT_W-1:0]    div_quo, div_quo_next;
  logic [CNT_W-1:0]     div_cnt;
  logic                 div_done;

  logic                 col_wrap;
  logic [TOTAL_W-1:0]   oc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(WIDTH_RST);
      image_height <= HEIGHT_W'(HEIGHT_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_W'(2))
      eff_w = WIDTH_W'(2);
    else if (image_width > WIDTH_W'(LINE_MAX))
      eff_w = WIDTH_W'(LINE_MAX);
    else
      eff_w = image_width;
    if (image_height < HEIGHT_W'(2))
      eff_h = HEIGHT_W'(2);
    else if (image_height > HEIGHT_W'(HEIGHT_MAX))
      eff_h = HEIGHT_W'(HEIGHT_MAX);
    else
      eff_h = image_height;
  end

  // frame size is a register behind the config registers; input is stalled meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= TOTAL_W'(WIDTH_RST * HEIGHT_RST);
    end else begin
      total <= TOTAL_W'(eff_w * eff_h);
    end
  end

  // ---- divider sequencer: (pos_row, pos_col) = out_count divmod eff_w ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (cfg_write) state_next = DIV_LOAD;
      DIV_LOAD: begin
        if (cfg_write) state_next = DIV_LOAD;
        else           state_next = DIV_RUN;
      end
      DIV_RUN: begin
        if (cfg_write)     state_next = DIV_LOAD;
        else if (div_done) state_next = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != DIV_IDLE);
    div_done = (state == DIV_RUN) && (div_cnt == CNT_W'(OCNT_W - 1));
  end

  always_comb begin
    rem_sh = {div_rem[WIDTH_W-2:0], div_quo[OCNT_W-1]};
    if (rem_sh >= eff_w) begin
      div_rem_next = rem_sh - eff_w;
      div_quo_next = {div_quo[OCNT_W-2:0], 1'b1};
    end else begin
      div_rem_next = rem_sh;
      div_quo_next = {div_quo[OCNT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_LOAD: begin
        div_rem <= '0;
        div_quo <= out_count;
        div_cnt <= '0;
      end
      DIV_RUN: begin
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
        div_cnt <= div_cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // ---- per-item decisions ----
  always_comb begin
    col_addr      = column_count;
    col_wrap      = ({1'b0, column_count} + WIDTH_W'(1)) >= eff_w;
    oc_inc        = {1'b0, out_count} + TOTAL_W'(1);
    ctl.emit      = (row_count >= ROW_W'(2)) ||
                    ((row_count == ROW_W'(1)) && (column_count != '0));
    ctl.last      = oc_inc >= total;
    ctl.top_rep   = (pos_row == '0);
    ctl.bot_rep   = ({1'b0, pos_row} + OCNT_W'(1)) >= OCNT_W'(eff_h);
    ctl.left_rep  = (pos_col == '0);
    ctl.right_rep = ({1'b0, pos_col} + WIDTH_W'(1)) >= eff_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      out_count    <= '0;
      pos_row      <= '0;
      pos_col      <= '0;
    end else if (div_done) begin
      pos_row <= div_quo_next[POS_ROW_W-1:0];
      pos_col <= div_rem_next[COL_W-1:0];
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        if (row_count < ROW_W'(ROW_SAT)) row_count <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          column_count <= '0;
          row_count    <= '0;
          out_count    <= '0;
          pos_row      <= '0;
          pos_col      <= '0;
        end else begin
          out_count <= oc_inc[OCNT_W-1:0];
          if (ctl.right_rep) begin
            pos_col <= '0;
            pos_row <= pos_row + POS_ROW_W'(1);
          end else begin
            pos_col <= pos_col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

FILE: hdl/bbr_line_buffer.sv
// ----------------------------------------------------------------------------
// bbr_line_buffer
// Two line stores holding the previous two lines, with the first pipeline
// stage that presents the incoming window column.
// ----------------------------------------------------------------------------
module bbr_line_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         advance,
  input  logic                         drain,
  input  logic [bbr_pkg::PIX_W-1:0]    pix,
  input  logic [bbr_pkg::COL_W-1:0]    addr,
  output logic                         s1_valid,
  output bbr_pkg::col_t                col
);
  import bbr_pkg::*;

  logic [PIX_W-1:0] mem_a [LINE_MAX];
  logic [PIX_W-1:0] mem_b [LINE_MAX];
  logic [PIX_W-1:0] rd_a, rd_b;
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_addr;
  logic             s1_drain;
  logic             fwd;
  logic [PIX_W-1:0] fwd_data;
  logic             a_we;

  // upper store takes the old middle value once the item leaves stage 1
  assign a_we = s1_valid && !s1_drain && advance;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_b <= mem_b[addr];
      if (!drain) mem_b[addr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[s1_addr] <= rd_b;
    if (accept) rd_a <= mem_a[addr];
  end

  // same-address write in the read cycle: forward the value being written
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd      <= a_we && (s1_addr == addr);
      fwd_data <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drain <= drain;
      s1_pix   <= drain ? '0 : pix;
      s1_addr  <= addr;
    end
  end

  always_comb begin
    col.top = fwd ? fwd_data : rd_a;
    col.mid = rd_b;
    col.bot = s1_pix;
  end

endmodule

FILE: hdl/bbr_window_sum.sv
// ----------------------------------------------------------------------------
// bbr_window_sum
// 3x3 window, replicated-edge sum and divide by nine into the result
// register.
// ----------------------------------------------------------------------------
module bbr_window_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 s1_valid,
  input  bbr_pkg::col_t        col,
  input  bbr_pkg::item_ctl_t   s1_ctl,
  output logic                 out_valid,
  output bbr_pkg::out_beat_t   out_data
);
  import bbr_pkg::*;

  col_t                       win [3];
  item_ctl_t                  s2_ctl;
  logic [COLSUM_W-1:0]        colsum [3];
  logic [SUM_W-1:0]           sum;
  logic                       s3_emit;
  logic                       s3_last;
  logic [SUM_W-1:0]           s3_sum;
  logic [SUM_W+RECIP_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) win[i] <= '0;
    end else if (advance && s1_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (advance) begin
      s2_ctl      <= s1_ctl;
      s2_ctl.emit <= s1_valid && s1_ctl.emit;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      colsum[j] = COLSUM_W'(s2_ctl.top_rep ? win[j].mid : win[j].top)
                + COLSUM_W'(win[j].mid)
                + COLSUM_W'(s2_ctl.bot_rep ? win[j].mid : win[j].bot);
    end
    sum = SUM_W'(s2_ctl.left_rep ? colsum[1] : colsum[0])
        + SUM_W'(colsum[1])
        + SUM_W'(s2_ctl.right_rep ? colsum[1] : colsum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else if (advance) begin
      s3_emit <= s2_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sum  <= sum;
      s3_last <= s2_ctl.last;
    end
  end

  assign prod = (SUM_W+RECIP_W)'(s3_sum) * (SUM_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.pixel_out  <= prod[RECIP_SHIFT +: PIX_W];
      out_data.frame_last <= s3_last;
    end
  end

endmodule

FILE: hdl/box_blur_3x3_replicate_unit.sv
// Path: the beat that completes a neighborhood (width+1 beats after the pixel)
//   passes stage 1, the window and the sum register into the result register.
// Throughput: one beat per cycle while not stalled; the 4-stage pipeline holds
//   only on output stall. After each config write the input stalls while the
//   serial divider rebuilds the output row/column from the output count.
// Reset: counters and window cleared, width/height 512; line stores not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_replicate_unit
// 3x3 mean blur over a raster grayscale stream with replicated edges.
// ----------------------------------------------------------------------------
module box_blur_3x3_replicate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bbr_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bbr_pkg::out_beat_t             out_data,
  input  logic                           cfg_write,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbr_pkg::*;

  logic             advance;
  logic             accept;
  logic             busy;
  logic [COL_W-1:0] col_addr;
  item_ctl_t        ctl;
  item_ctl_t        s1_ctl;
  logic             s1_valid;
  col_t             col;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance || busy;
  assign accept   = in_valid && !in_stall;

  bbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .busy      (busy),
    .col_addr  (col_addr),
    .ctl       (ctl)
  );

  bbr_line_buffer u_line_buffer (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .advance  (advance),
    .drain    (in_data.item_kind),
    .pix      (in_data.pixel_in),
    .addr     (col_addr),
    .s1_valid (s1_valid),
    .col      (col)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
    end
  end

  bbr_window_sum u_window_sum (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .col       (col),
    .s1_ctl    (s1_ctl),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams raster frames through the 3x3 replicate-edge box blur and compares
// every output beat with an in-bench model of the line stores and window.
// Frame sizes run from the clamped minimum up to full width and full height.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbr_pkg::*;

  localparam bit KIND_PIXEL    = 1'b0;
  localparam bit KIND_DRAIN    = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_ITEMS    = 1550;
  localparam int CYCLE_LIMIT   = 1200000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  box_blur_3x3_replicate_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int         cycle_cnt = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit         in_fire   = 1'b0;

  in_beat_t   pixel_feed[$];
  out_beat_t  blurred_q[$];

  int beats_in       = 0;
  int pixels_checked = 0;
  int frames_done    = 0;
  int cfg_writes     = 0;
  int bad_beats      = 0;

  // blur model state
  bit [WIDTH_W-1:0]  cur_width  = WIDTH_RST;
  bit [HEIGHT_W-1:0] cur_height = HEIGHT_RST;
  bit [PIX_W-1:0]    line_top [LINE_MAX];
  bit [PIX_W-1:0]    line_mid [LINE_MAX];
  bit [PIX_W-1:0]    win [3][3];  // [top/mid/bot][old..new]
  bit [COL_W-1:0]    col_pos;
  bit [ROW_W-1:0]    row_pos;
  bit [TOTAL_W-1:0]  out_pos;

  function automatic int unsigned eff_width();
    int unsigned v;
    v = cur_width;
    if (v < 2) v = 2;
    if (v > LINE_MAX) v = LINE_MAX;
    return v;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned v;
    v = cur_height;
    if (v < 2) v = 2;
    if (v > HEIGHT_MAX) v = HEIGHT_MAX;
    return v;
  endfunction

  // Advances the model by one beat; returns 1 when the beat releases a pixel.
  function automatic bit blur_predict(input in_beat_t beat, output out_beat_t res);
    int unsigned    w, h, col, r, c, sum;
    bit [PIX_W-1:0] pix, top, mid;
    bit             emit;
    int             rs[3], cs[3];
    w   = eff_width();
    h   = eff_height();
    pix = (beat.item_kind == KIND_DRAIN) ? '0 : beat.pixel_in;
    col = col_pos;
    top = line_top[col];
    mid = line_mid[col];
    emit = (row_pos >= 2) || (row_pos == 1 && col >= 1);
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (beat.item_kind != KIND_DRAIN) begin
      line_top[col] = mid;
      line_mid[col] = pix;
    end
    if (col + 1 >= w) begin
      col_pos = '0;
      if (row_pos < ROW_SAT) row_pos++;
    end else begin
      col_pos = col + 1;
    end
    res = '0;
    if (emit) begin
      r = out_pos / w;
      c = out_pos % w;
      // edge replication: swap the missing neighbor row/column for the center
      rs[0] = (r == 0) ? 1 : 0;
      rs[1] = 1;
      rs[2] = (r + 1 >= h) ? 1 : 2;
      cs[0] = (c == 0) ? 1 : 0;
      cs[1] = 1;
      cs[2] = (c + 1 >= w) ? 1 : 2;
      sum = 0;
      foreach (rs[a]) foreach (cs[b]) sum += win[rs[a]][cs[b]];
      out_pos++;
      res.pixel_out  = sum / 9;
      res.frame_last = (out_pos >= w * h);
      if (res.frame_last) begin
        col_pos = '0;
        row_pos = '0;
        out_pos = '0;
      end
    end
    return emit;
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // input beats and config writes feed the model; output beats are checked
  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) cur_width = cfg_data[WIDTH_W-1:0];
        else cur_height = cfg_data[HEIGHT_W-1:0];
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        beats_in++;
        if (blur_predict(in_data, want)) blurred_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $error("output beat with no pixel pending: pixel_out=%0d frame_last=%0d",
                 out_data.pixel_out, out_data.frame_last);
          bad_beats++;
        end else begin
          want = blurred_q.pop_front();
          if (out_data.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_data.pixel_out);
            bad_beats++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d",
                   want.frame_last, out_data.frame_last);
            bad_beats++;
          end
          pixels_checked++;
          if (want.frame_last) frames_done++;
        end
      end
    end
  end

  always @(negedge clk) begin : feeder
    int send_pct, recv_pct;
    case (idle_mode)
      IDLE_SEND: begin send_pct = 70; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 70; end
      IDLE_BOTH: begin send_pct = 15; recv_pct = 15; end
      default:   begin send_pct = 0;  recv_pct = 0;  end
    endcase
    if (cycle_cnt[7:0] == 8'd0) idle_mode <= idle_mode_t'($urandom_range(0, 3));
    out_stall <= ($urandom_range(0, 99) < recv_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_data  <= pixel_feed.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_pixel(input bit [PIX_W-1:0] v);
    pixel_feed.push_back('{item_kind: KIND_PIXEL, pixel_in: v});
  endtask

  task automatic push_drain();
    pixel_feed.push_back('{item_kind: KIND_DRAIN, pixel_in: PIX_W'($urandom_range(0, 255))});
  endtask

  task automatic push_random_pixels(input int n);
    repeat (n) push_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // all beats sent, all pixels out, pipeline given time to empty
  task automatic wait_quiet();
    while (pixel_feed.size() != 0 || in_valid || blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int  w, h, ew, eh, len, roll, rand_items;
    bit  first;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry 512x512; cut to two lines mid-frame once some pixels are out
    push_random_pixels(520);
    wait_quiet();
    write_reg(REG_HEIGHT, 13'd2);
    push_random_pixels(504);
    repeat (513) push_drain();

    // full line width (clamped from all ones), height clamped up from zero
    wait_quiet();
    write_reg(REG_WIDTH, '1);
    write_reg(REG_HEIGHT, '0);
    push_random_pixels(2048);
    repeat (1025) push_drain();

    // smallest frame, saturated pixels
    wait_quiet();
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd1);
    repeat (4) push_pixel(8'hFF);
    repeat (3) push_drain();

    // shrink height below the output count already reached: next beat ends frame
    wait_quiet();
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_HEIGHT, 13'd4);
    push_random_pixels(7);
    wait_quiet();
    write_reg(REG_HEIGHT, 13'd0);
    push_drain();

    // 4x2 with a drain tick inside the frame and pixel beats in the tail
    wait_quiet();
    write_reg(REG_WIDTH, 13'd4);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_drain();
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h80);
    push_random_pixels(5);

    // full height (clamped from all ones); row counter saturates
    wait_quiet();
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_HEIGHT, '1);
    push_random_pixels(8192);
    repeat (3) push_drain();

    rand_items = 0;
    first = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      if (first || $urandom_range(0, 99) < 60) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) w = $urandom_range(0, 1);
        else if (roll < 80) w = $urandom_range(2, 10);
        else w = $urandom_range(11, 48);
        roll = $urandom_range(0, 99);
        if (roll < 5) h = $urandom_range(0, 1);
        else if (roll < 85) h = $urandom_range(2, 6);
        else h = $urandom_range(7, 16);
        wait_quiet();
        // upper data bits are outside the width register
        write_reg(REG_WIDTH, {2'($urandom_range(0, 3)), 11'(w)});
        write_reg(REG_HEIGHT, 13'(h));
        first = 1'b0;
      end
      ew = eff_width();
      eh = eff_height();
      len = ew * eh;
      roll = $urandom_range(0, 99);
      if (roll < 15) len = $urandom_range(1, len);  // truncated frame
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 3) push_drain();
        else push_pixel(PIX_W'($urandom_range(0, 255)));
      end
      rand_items += len;
      if (roll >= 15) begin
        for (int i = 0; i <= ew; i++) begin
          if ($urandom_range(0, 99) < 10) push_pixel(PIX_W'($urandom_range(0, 255)));
          else push_drain();
        end
        rand_items += ew + 1;
      end
    end

    wait_quiet();
    $display("Ran %0d input beats across %0d config writes, widths up to 1024, heights up to 4096.",
             beats_in, cfg_writes);
    $display("Checked %0d blurred pixels over %0d frame ends, %0d mismatches.",
             pixels_checked, frames_done, bad_beats);
    if (bad_beats == 0 && blurred_q.size() == 0) begin
      $display("[box_blur_3x3_replicate_unit] OK");
    end else begin
      $display("[box_blur_3x3_replicate_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d pixels still expected.",
             cycle_cnt, blurred_q.size());
    $display("[box_blur_3x3_replicate_unit] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bbr_pkg.sv
hdl/bbr_ctrl.sv
hdl/bbr_line_buffer.sv
hdl/bbr_window_sum.sv
hdl/box_blur_3x3_replicate_unit.sv
verif/tb_top.sv
